// ===== sv/bfsa_pkg.sv =====
// ---------------------------------------------------------------------------
// Best-fit segment allocator package
// Shared opcodes, status codes and controller/datapath command and status.
// ---------------------------------------------------------------------------
package bfsa_pkg;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_OVERLAP = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_FAIL   = 2'd2;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan_start;
    logic scan_step;
    logic scan_last;
    logic commit;
  } bfsa_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       scan_done;
    logic [2:0] status;
  } bfsa_sts_t;

endpackage

// ===== sv/best_fit_segment_allocator.sv =====
// ---------------------------------------------------------------------------
// Best-fit segment allocator
// Allocate and free each scan the whole table, one table read per cycle, then commit.
// Init and unused opcode: result in the cycle after acceptance.
// One item at a time; next item accepted once the result has been taken.
// Synchronous reset empties the table and restores register defaults.
// ---------------------------------------------------------------------------
module best_fit_segment_allocator import bfsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_request_start,
  input  logic [31:0] in_request_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_address,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] region_start_r, region_length_r, failure_value_r;
  bfsa_cmd_t cmd;
  bfsa_sts_t sts;
  logic init_op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r  <= 32'd0;
      region_length_r <= 32'd65536;
      failure_value_r <= 32'hFFFF_FFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START:  region_start_r  <= cfg_data;
        REG_LENGTH: region_length_r <= cfg_data;
        REG_FAIL:   failure_value_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [ADDR_BITS-1:0] rstart, rlen;
  assign rstart = ADDR_BITS >= 32 ? ADDR_BITS'(region_start_r)  : region_start_r[ADDR_BITS-1:0];
  assign rlen   = ADDR_BITS >= 32 ? ADDR_BITS'(region_length_r) : region_length_r[ADDR_BITS-1:0];

  assign init_op = in_opcode[1];
  assign out_status = sts.status;

  bfsa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .init_op, .cmd, .sts
  );

  bfsa_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_opcode, .in_request_start, .in_request_length,
    .region_start(rstart), .region_length(rlen), .failure_value(failure_value_r),
    .out_result_address
  );

endmodule

// ===== sv/bfsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// Best-fit segment allocator controller
// Sequences clearing, table scan, commit and result handover.
// ---------------------------------------------------------------------------
module bfsa_ctrl import bfsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  logic      init_op,
  output bfsa_cmd_t cmd,
  input  bfsa_sts_t sts
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_FINAL, S_COMMIT, S_OUT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          if (init_op) begin
            state_nxt = S_CLEAR;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_FINAL;
      end
      S_FINAL: begin
        cmd.scan_last = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/bfsa_dp.sv =====
// ---------------------------------------------------------------------------
// Best-fit segment allocator datapath
// Segment memory, valid bits, scan comparators and result register.
// ---------------------------------------------------------------------------
module bfsa_dp import bfsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfsa_cmd_t            cmd,
  output bfsa_sts_t            sts,
  input  logic [1:0]           in_opcode,
  input  logic [31:0]          in_request_start,
  input  logic [31:0]          in_request_length,
  input  logic [ADDR_BITS-1:0] region_start,
  input  logic [ADDR_BITS-1:0] region_length,
  input  logic [31:0]          failure_value,
  output logic [31:0]          out_result_address
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = IW + 1;
  localparam logic [ADDR_BITS-1:0] AMAX = '1;

  logic [ADDR_BITS-1:0] mem_s [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0] mem_l [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] valid_r;

  logic [1:0]           op_r;
  logic [ADDR_BITS-1:0] rs_r, rl_r;
  logic [CW-1:0]        cnt_r;
  logic                 rd_v_r;
  logic [IW-1:0]        rd_i_r;
  logic [ADDR_BITS-1:0] rd_s_r, rd_l_r;

  logic                 best_f_r, left_f_r, right_f_r, slot_f_r;
  logic [IW-1:0]        best_i_r, left_i_r, right_i_r, slot_i_r;
  logic [ADDR_BITS-1:0] best_s_r, best_l_r, left_s_r, left_l_r, right_s_r, right_l_r;
  logic [2:0]           status_r;
  logic [31:0]          addr_r;

  logic [ADDR_BITS-1:0] in_s, in_l;
  assign in_s = ADDR_BITS >= 32 ? ADDR_BITS'(in_request_start)  : in_request_start[ADDR_BITS-1:0];
  assign in_l = ADDR_BITS >= 32 ? ADDR_BITS'(in_request_length) : in_request_length[ADDR_BITS-1:0];

  logic [IW-1:0] idx;
  assign idx = cnt_r[IW-1:0];
  logic last_rd;
  assign last_rd = (cnt_r == CW'(MAX_SEGMENTS - 1));

  assign sts.clear_done = 1'b1;
  assign sts.scan_done  = last_rd;
  assign sts.status     = status_r;
  assign out_result_address = addr_r;

  // decision from scan registers
  logic ml, mr, ovl, past;
  logic [ADDR_BITS-1:0] lgap, rgap;
  assign lgap = rs_r - left_s_r;
  assign rgap = right_s_r - rs_r;
  assign past = rl_r > (AMAX - rs_r);
  assign ovl  = (left_f_r && left_l_r > lgap) || (right_f_r && rl_r > rgap);
  assign ml   = left_f_r && left_l_r == lgap;
  assign mr   = right_f_r && rl_r == rgap;

  logic [ADDR_BITS-1:0] clip_l;
  assign clip_l = (region_length > AMAX - region_start) ? AMAX - region_start : region_length;

  always_ff @(posedge clk) begin
    rd_v_r <= 1'b0;
    if (cmd.load) begin
      op_r  <= in_opcode;
      rs_r  <= in_s;
      rl_r  <= in_l;
      cnt_r <= '0;
      best_f_r <= 1'b0; left_f_r <= 1'b0; right_f_r <= 1'b0; slot_f_r <= 1'b0;
      status_r <= ST_OK;
      addr_r   <= '0;
      if (in_opcode == OP_INIT && clip_l != '0) begin
        mem_s[0] <= region_start;
        mem_l[0] <= clip_l;
      end
    end
    if (cmd.scan_step || cmd.scan_start) begin
      if (cmd.scan_step) cnt_r <= cnt_r + CW'(1);
      rd_v_r <= valid_r[idx];
      rd_i_r <= idx;
      rd_s_r <= mem_s[idx];
      rd_l_r <= mem_l[idx];
    end
    if ((cmd.scan_step || cmd.scan_last) && cnt_r != '0) begin
      if (!rd_v_r) begin
        if (!slot_f_r) begin slot_f_r <= 1'b1; slot_i_r <= rd_i_r; end
      end else begin
        if (rd_l_r >= rl_r && (!best_f_r || rd_l_r < best_l_r ||
            (rd_l_r == best_l_r && rd_s_r < best_s_r))) begin
          best_f_r <= 1'b1; best_i_r <= rd_i_r; best_s_r <= rd_s_r; best_l_r <= rd_l_r;
        end
        if (rd_s_r < rs_r) begin
          if (!left_f_r || rd_s_r > left_s_r) begin
            left_f_r <= 1'b1; left_i_r <= rd_i_r; left_s_r <= rd_s_r; left_l_r <= rd_l_r;
          end
        end else if (!right_f_r || rd_s_r < right_s_r) begin
          right_f_r <= 1'b1; right_i_r <= rd_i_r; right_s_r <= rd_s_r; right_l_r <= rd_l_r;
        end
      end
    end
    if (cmd.commit) begin
      if (op_r == OP_ALLOC) begin
        if (rl_r == '0) begin
          status_r <= ST_ZERO; addr_r <= failure_value;
        end else if (!best_f_r) begin
          status_r <= ST_NOFIT; addr_r <= failure_value;
        end else begin
          addr_r <= 32'(best_s_r);
          if (best_l_r != rl_r) begin
            mem_s[best_i_r] <= best_s_r + rl_r;
            mem_l[best_i_r] <= best_l_r - rl_r;
          end
        end
      end else if (op_r == OP_FREE) begin
        if (rl_r == '0) status_r <= ST_ZERO;
        else if (past || ovl) status_r <= ST_OVERLAP;
        else if (!ml && !mr && !slot_f_r) status_r <= ST_FULL;
        else if (ml && mr) mem_l[left_i_r] <= left_l_r + rl_r + right_l_r;
        else if (ml) mem_l[left_i_r] <= left_l_r + rl_r;
        else if (mr) begin
          mem_s[right_i_r] <= rs_r;
          mem_l[right_i_r] <= right_l_r + rl_r;
        end else begin
          mem_s[slot_i_r] <= rs_r;
          mem_l[slot_i_r] <= rl_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.load && in_opcode == OP_INIT) begin
      valid_r    <= '0;
      valid_r[0] <= clip_l != '0;
    end else if (cmd.commit) begin
      if (op_r == OP_ALLOC) begin
        if (rl_r != '0 && best_f_r && best_l_r == rl_r) valid_r[best_i_r] <= 1'b0;
      end else if (op_r == OP_FREE && rl_r != '0 && !past && !ovl) begin
        if (ml && mr) valid_r[right_i_r] <= 1'b0;
        else if (!ml && !mr && slot_f_r) valid_r[slot_i_r] <= 1'b1;
      end
    end
  end

endmodule

// ===== sim/best_fit_segment_allocator_test.sv =====
// ---------------------------------------------------------------------------
// Best-fit segment allocator testbench
// Drives allocate, free and init items against a local model of the free
// segment table, with bursty input, receiver stalls and register changes.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module best_fit_segment_allocator_test;
  import bfsa_pkg::*;

  localparam int NSEG = 64;
  localparam logic [31:0] TOP = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  status;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [31:0] reg_start, reg_length, reg_fail;
    logic [31:0] seg_start[NSEG];
    logic [31:0] seg_length[NSEG];
    bit          seg_valid[NSEG];
    alloc_result_t pending[$];
    int mismatches, checked;

    function new();
      reg_start = 0; reg_length = 32'd65536; reg_fail = TOP;
      foreach (seg_valid[i]) begin
        seg_valid[i] = 0; seg_start[i] = 0; seg_length[i] = 0;
      end
      mismatches = 0; checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] d);
      case (idx)
        REG_START:  reg_start = d;
        REG_LENGTH: reg_length = d;
        REG_FAIL:   reg_fail = d;
        default: ;
      endcase
    endfunction

    function alloc_result_t run_alloc(logic [31:0] len);
      alloc_result_t r;
      int best;
      best = -1;
      if (len == 0) return '{reg_fail, ST_ZERO};
      for (int i = 0; i < NSEG; i++) begin
        if (!seg_valid[i] || seg_length[i] < len) continue;
        if (best < 0 || seg_length[i] < seg_length[best] ||
            (seg_length[i] == seg_length[best] && seg_start[i] < seg_start[best]))
          best = i;
      end
      if (best < 0) return '{reg_fail, ST_NOFIT};
      r = '{seg_start[best], ST_OK};
      if (seg_length[best] == len) seg_valid[best] = 0;
      else begin
        seg_start[best] += len;
        seg_length[best] -= len;
      end
      return r;
    endfunction

    function logic [2:0] run_free(logic [31:0] s, logic [31:0] len);
      int l, rt, slot;
      bit ml, mr;
      l = -1; rt = -1; slot = -1;
      if (len == 0) return ST_ZERO;
      if (len > TOP - s) return ST_OVERLAP;
      for (int i = 0; i < NSEG; i++) begin
        if (!seg_valid[i]) begin
          if (slot < 0) slot = i;
        end else if (seg_start[i] < s) begin
          if (l < 0 || seg_start[i] > seg_start[l]) l = i;
        end else if (rt < 0 || seg_start[i] < seg_start[rt]) rt = i;
      end
      if ((l >= 0 && seg_length[l] > s - seg_start[l]) ||
          (rt >= 0 && len > seg_start[rt] - s)) return ST_OVERLAP;
      ml = l >= 0 && seg_length[l] == s - seg_start[l];
      mr = rt >= 0 && len == seg_start[rt] - s;
      if (!ml && !mr && slot < 0) return ST_FULL;
      if (ml && mr) begin
        seg_length[l] += len + seg_length[rt];
        seg_valid[rt] = 0;
      end else if (ml) seg_length[l] += len;
      else if (mr) begin
        seg_start[rt] = s;
        seg_length[rt] += len;
      end else begin
        seg_valid[slot] = 1; seg_start[slot] = s; seg_length[slot] = len;
      end
      return ST_OK;
    endfunction

    function void run_init();
      logic [31:0] len;
      len = reg_length;
      foreach (seg_valid[i]) begin
        seg_valid[i] = 0; seg_start[i] = 0; seg_length[i] = 0;
      end
      if (len > TOP - reg_start) len = TOP - reg_start;
      if (len != 0) begin
        seg_valid[0] = 1; seg_start[0] = reg_start; seg_length[0] = len;
      end
    endfunction

    function void note_item(logic [1:0] op, logic [31:0] s, logic [31:0] len);
      alloc_result_t r;
      r = '{32'd0, ST_OK};
      case (op)
        OP_ALLOC: r = run_alloc(len);
        OP_FREE:  r.status = run_free(s, len);
        OP_INIT:  run_init();
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] a, logic [2:0] st);
      alloc_result_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result addr=%h status=%0d", a, st);
        return;
      end
      e = pending.pop_front();
      if (e.addr !== a || e.status !== st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                   e.addr, e.status, a, st);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [1:0] in_opcode = 0;
  logic [31:0] in_request_start = 0, in_request_length = 0;
  logic out_valid, out_ready = 0;
  logic [31:0] out_result_address;
  logic [2:0] out_status;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  alloc_scoreboard sb = new();
  logic [31:0] live_start[$];
  logic [31:0] live_length[$];
  int hold_off = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int stall_mode = 0;
  int n_items = 0;

  always #6 clk = ~clk;

  best_fit_segment_allocator uut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_result_address, out_status);
    if (rst_n && in_valid && in_ready)
      sb.note_item(in_opcode, in_request_start, in_request_length);
  end

  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_off <= 300;
      out_ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else case (stall_mode)
      0: out_ready <= 1;
      1: out_ready <= ($urandom_range(3) != 0);
      default: out_ready <= ($urandom_range(3) == 0);
    endcase
  end

  task automatic send_item(logic [1:0] op, logic [31:0] s, logic [31:0] len);
    in_valid <= 1;
    in_opcode <= op;
    in_request_start <= s;
    in_request_length <= len;
    do @(posedge clk); while (!in_ready);
    in_valid <= 0;
    @(posedge clk);
    n_items++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_phase(int count, logic [31:0] base, int span);
    logic [31:0] len, s;
    int k, burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        repeat ($urandom_range(0, 10)) @(posedge clk);
        burst = $urandom_range(1, 12);
      end
      burst--;
      k = $urandom_range(9);
      if (k < 4) begin
        len = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, span);
        if ($urandom_range(15) == 0) len = 0;
        sb_alloc_track(len);
      end else if (k < 8 && live_start.size() != 0) begin
        int j;
        j = $urandom_range(live_start.size() - 1);
        send_item(OP_FREE, live_start[j], live_length[j]);
        live_start.delete(j);
        live_length.delete(j);
      end else if (k == 8) begin
        s = ($urandom_range(1)) ? $urandom : base + $urandom_range(span * 8);
        len = ($urandom_range(1)) ? $urandom : $urandom_range(0, span);
        send_item(OP_FREE, s, len);
      end else
        send_item(($urandom_range(3) == 0) ? OP_NOP : OP_ALLOC, $urandom, $urandom);
    end
  endtask

  // allocations are tracked so that later frees return real blocks
  task automatic sb_alloc_track(logic [31:0] len);
    alloc_result_t r;
    send_item(OP_ALLOC, $urandom, len);
    if ($urandom_range(3) == 0) begin
      @(posedge clk);
      while (sb.pending.size() != 0) @(posedge clk);
    end
    // peek the model for the address it gave
    r = '{32'd0, ST_OK};
    if (sb.pending.size() != 0) r = sb.pending[$];
    if (sb.pending.size() != 0 && r.status == ST_OK && len != 0) begin
      live_start.push_back(r.addr);
      live_length.push_back(len);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_reg(REG_START, 32'h1000);
    write_reg(REG_LENGTH, 32'd4096);
    write_reg(REG_FAIL, 32'hDEAD_BEEF);
    send_item(OP_ALLOC, 0, 32'd16);
    send_item(OP_INIT, 0, 0);
    send_item(OP_ALLOC, TOP, 0);
    send_item(OP_ALLOC, 0, TOP);
    send_item(OP_ALLOC, 0, 32'd256);
    send_item(OP_ALLOC, 0, 32'd256);
    send_item(OP_FREE, 32'h1000, 32'd128);
    send_item(OP_FREE, 32'h1080, 32'd128);
    send_item(OP_FREE, 32'h1100, 32'd100);
    send_item(OP_FREE, 32'h1100, 32'd0);
    send_item(OP_FREE, 32'h1000, 32'd256);
    send_item(OP_FREE, 32'h1800, 32'd16);
    send_item(OP_FREE, 32'hFFFF_FFF0, 32'd16);
    send_item(OP_FREE, 32'hFFFF_FFF0, 32'd15);
    send_item(OP_ALLOC, 0, 32'd15);
    send_item(OP_NOP, TOP, TOP);
    send_item(OP_ALLOC, TOP, 32'd1);
    drain();

    // fill the table with isolated holes to reach table full
    write_reg(REG_LENGTH, 32'd0);
    send_item(OP_INIT, 0, 0);
    for (int i = 0; i < NSEG + 2; i++) send_item(OP_FREE, 32'h10 * i, 32'd8);
    send_item(OP_FREE, 32'h8, 32'd8);
    send_item(OP_ALLOC, 0, 32'd16);
    drain();

    write_reg(REG_START, 32'hFFFF_0000);
    write_reg(REG_LENGTH, TOP);
    write_reg(REG_FAIL, 32'd0);
    send_item(OP_INIT, 0, 0);
    send_item(OP_ALLOC, 0, 32'hFFFF);
    send_item(OP_ALLOC, 0, 32'd1);
    drain();

    write_reg(REG_START, 32'h0);
    write_reg(REG_LENGTH, 32'd65536);
    write_reg(REG_FAIL, TOP);
    send_item(OP_INIT, 0, 0);
    live_start.delete(); live_length.delete();
    stall_mode = 1;
    random_phase(150, 32'h0, 512);

    hold_req = hold_req + 1;
    for (int i = 0; i < 6; i++) send_item(OP_ALLOC, 0, $urandom_range(1, 64));
    drain();

    write_reg(REG_START, $urandom);
    write_reg(REG_LENGTH, $urandom);
    write_reg(REG_FAIL, $urandom);
    send_item(OP_INIT, 0, 0);
    live_start.delete(); live_length.delete();
    stall_mode = 2;
    random_phase(150, sb.reg_start, 1 << 20);
    drain();

    write_reg(REG_START, 32'h4000);
    write_reg(REG_LENGTH, 32'd4096);
    send_item(OP_INIT, 0, 0);
    live_start.delete(); live_length.delete();
    stall_mode = 0;
    random_phase(150, 32'h4000, 64);
    drain();

    $display("ran %0d items, %0d results checked, over several region settings",
             n_items, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("best_fit_segment_allocator_test OK");
    else
      $display("best_fit_segment_allocator_test NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("best_fit_segment_allocator_test NOT OK");
    $finish;
  end

endmodule
